>>> src/ccbri_pkg.sv
package ccbri_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // One beat moving down the round chain: working state, the original
  // state for the final feed-forward add, and the modulus riding along.
  typedef struct packed {
    state_t      st;
    state_t      init;
    logic [63:0] modulus;
  } beat_t;

  // Roles of the four words in a quarter round (row of the 4x4 matrix).
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  localparam int unsigned STEPS_PER_ROUND = 4;
  localparam int unsigned ROUNDS_PER_DOUBLE = 2;
  localparam int unsigned ROT_AMT [STEPS_PER_ROUND] = '{16, 12, 8, 7};

  // Word index of a role in a lane; the diagonal round shifts each row.
  function automatic logic [3:0] qr_idx(input logic diag, input logic [1:0] lane,
                                        input logic [1:0] role);
    logic [1:0] col;
    col = diag ? lane + role : lane;
    return {role, col};
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

>>> src/ccbri_round_cell.sv
module ccbri_round_cell #(
  parameter int unsigned STEP = 0,
  parameter bit          DIAG = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ccbri_pkg::beat_t beat_i,
  output logic            valid_o,
  output ccbri_pkg::beat_t beat_o
);
  import ccbri_pkg::*;

  // Even steps update a from b and mix into d; odd steps update c from d
  // and mix into b.
  localparam bit          ODD  = (STEP % 2) == 1;
  localparam logic [1:0]  XR   = ODD ? ROLE_C : ROLE_A;
  localparam logic [1:0]  YR   = ODD ? ROLE_D : ROLE_B;
  localparam logic [1:0]  ZR   = ODD ? ROLE_B : ROLE_D;
  localparam int unsigned ROT  = ROT_AMT[STEP];

  logic  valid_q;
  beat_t beat_d, beat_q;

  always_comb begin
    word_t sum;
    beat_d = beat_i;
    for (int l = 0; l < 4; l++) begin
      sum = beat_i.st[qr_idx(DIAG, 2'(l), XR)] + beat_i.st[qr_idx(DIAG, 2'(l), YR)];
      beat_d.st[qr_idx(DIAG, 2'(l), XR)] = sum;
      beat_d.st[qr_idx(DIAG, 2'(l), ZR)] =
        rotl(beat_i.st[qr_idx(DIAG, 2'(l), ZR)] ^ sum, ROT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> src/ccbri_bound.sv
module ccbri_bound (
  input  logic         clk_i,
  input  logic [63:0]  modulus_i,
  input  logic [127:0] value_i,
  input  logic [63:0]  offset_i,
  output logic [63:0]  sample_o
);
  import ccbri_pkg::*;

  // Full 64 x 128 product from 32 x 32 partial products, top 64 bits kept.
  logic [63:0]  pp_d [2][4];
  logic [63:0]  pp_q [2][4];
  logic [159:0] acc_d [2];
  logic [159:0] acc_q [2];
  logic [191:0] prod_d, prod_q;
  logic [63:0]  sample_d, sample_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 4; j++) begin
        pp_d[i][j] = {32'b0, modulus_i[32*i +: 32]} * {32'b0, value_i[32*j +: 32]};
      end
    end
    // Even and odd word products do not overlap, so each pair concatenates.
    for (int i = 0; i < 2; i++) begin
      acc_d[i] = {32'b0, pp_q[i][2], pp_q[i][0]} + {pp_q[i][3], pp_q[i][1], 32'b0};
    end
    prod_d   = {32'b0, acc_q[0]} + {acc_q[1], 32'b0};
    sample_d = prod_q[191:128] + offset_i;
  end

  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    sample_q <= sample_d;
  end

  assign sample_o = sample_q;

endmodule

>>> src/chacha20_bounded_random_int_core.sv
// Throughput: one block per cycle; busy_o stays low and start is always taken.
// Each cell of the round chain performs one add-xor-rotate line on all four
// lanes, followed by a feed-forward stage and a four-stage multiply pipeline.
// Reset clears the valid bits and sets counter_step to 1 and result_offset to 0.
// Results are shown for one cycle under valid_o; the receiver cannot stall.
module chacha20_bounded_random_int_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [63:0]        words_0_1_i,
  input  logic [63:0]        words_2_3_i,
  input  logic [63:0]        words_4_5_i,
  input  logic [63:0]        words_6_7_i,
  input  logic [63:0]        words_8_9_i,
  input  logic [63:0]        words_10_11_i,
  input  logic [63:0]        words_12_13_i,
  input  logic [63:0]        words_14_15_i,
  input  logic [63:0]        modulus_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic signed [63:0] sample_0_o,
  output logic signed [63:0] sample_1_o,
  output logic signed [63:0] sample_2_o,
  output logic signed [63:0] sample_3_o,
  output logic [63:0]        next_counter_o
);
  import ccbri_pkg::*;

  localparam int unsigned NCELL    = DOUBLE_ROUNDS * ROUNDS_PER_DOUBLE * STEPS_PER_ROUND;
  localparam int unsigned MUL_LAT  = 4;
  localparam logic [1:0]  CFG_STEP   = 2'd0;
  localparam logic [1:0]  CFG_OFFSET = 2'd1;

  logic [31:0]        step_q;
  logic signed [63:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= 32'd1;
      offset_q <= 64'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP:   step_q   <= cfg_wdata_i[31:0];
        CFG_OFFSET: offset_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  beat_t  chain_beat [NCELL+1];
  logic   chain_vld  [NCELL+1];
  state_t in_state;

  // Word 2m sits in the low half of each input pair, so the pairs line up
  // with the packed state directly.
  assign in_state = {words_14_15_i, words_12_13_i, words_10_11_i, words_8_9_i,
                     words_6_7_i, words_4_5_i, words_2_3_i, words_0_1_i};
  assign chain_beat[0] = {in_state, in_state, modulus_i};
  assign chain_vld[0]  = start_i;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    localparam int unsigned STEP = g % STEPS_PER_ROUND;
    localparam bit          DIAG = ((g / STEPS_PER_ROUND) % ROUNDS_PER_DOUBLE) == 1;
    ccbri_round_cell #(
      .STEP (STEP),
      .DIAG (DIAG)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[g]),
      .beat_i  (chain_beat[g]),
      .valid_o (chain_vld[g+1]),
      .beat_o  (chain_beat[g+1])
    );
  end

  // Feed-forward add and counter advance.
  logic        ff_vld_q;
  state_t      blk_d, blk_q;
  logic [63:0] ff_mod_q;
  logic [63:0] ff_cnt_d, ff_cnt_q;

  always_comb begin
    for (int w = 0; w < 16; w++) begin
      blk_d[w] = chain_beat[NCELL].st[w] + chain_beat[NCELL].init[w];
    end
    ff_cnt_d = {chain_beat[NCELL].init[13], chain_beat[NCELL].init[12]} + {32'b0, step_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_vld_q <= 1'b0;
    end else begin
      ff_vld_q <= chain_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    ff_mod_q <= chain_beat[NCELL].modulus;
    ff_cnt_q <= ff_cnt_d;
  end

  logic [63:0] sample [4];

  for (genvar k = 0; k < 4; k++) begin : g_bound
    ccbri_bound u_bound (
      .clk_i     (clk_i),
      .modulus_i (ff_mod_q),
      .value_i   ({blk_q[4*k+2], blk_q[4*k+3], blk_q[4*k], blk_q[4*k+1]}),
      .offset_i  (offset_q),
      .sample_o  (sample[k])
    );
  end

  logic        mul_vld_q [MUL_LAT];
  logic [63:0] mul_cnt_q [MUL_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MUL_LAT; s++) begin
        mul_vld_q[s] <= 1'b0;
      end
    end else begin
      mul_vld_q[0] <= ff_vld_q;
      for (int s = 1; s < MUL_LAT; s++) begin
        mul_vld_q[s] <= mul_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_cnt_q[0] <= ff_cnt_q;
    for (int s = 1; s < MUL_LAT; s++) begin
      mul_cnt_q[s] <= mul_cnt_q[s-1];
    end
  end

  assign valid_o        = mul_vld_q[MUL_LAT-1];
  assign next_counter_o = mul_cnt_q[MUL_LAT-1];
  assign sample_0_o     = sample[0];
  assign sample_1_o     = sample[1];
  assign sample_2_o     = sample[2];
  assign sample_3_o     = sample[3];

endmodule
